[design/ccl_pkg.sv]
// Shared types and constants for the crypto command line parser.
// No dependencies; every other design file but ccl_stream_if imports this package.
package ccl_pkg;

   localparam int ByteW  = 8;
   localparam int CountW = 12;
   localparam int IndexW = 8;
   localparam int AccumW = 9;

   // Register indexes on the csr port
   localparam logic CSR_DATA_CAPACITY = 1'b0;
   localparam logic CSR_MAX_KEY_INDEX = 1'b1;

   localparam logic [CountW-1:0] CAPACITY_RESET = 12'hFFF;
   localparam logic [IndexW-1:0] MAX_INDEX_RESET = 8'hFF;
   localparam logic [AccumW-1:0] ACCUM_SAT = 9'd511;

   // Characters
   localparam logic [ByteW-1:0] CHAR_NUL   = 8'h00;
   localparam logic [ByteW-1:0] CHAR_NL    = 8'h0A;
   localparam logic [ByteW-1:0] CHAR_COLON = 8'h3A;
   localparam logic [ByteW-1:0] CHAR_0     = 8'h30;
   localparam logic [ByteW-1:0] CHAR_9     = 8'h39;
   localparam logic [ByteW-1:0] CHAR_UA    = 8'h41;
   localparam logic [ByteW-1:0] CHAR_UZ    = 8'h5A;
   localparam logic [ByteW-1:0] CHAR_LA    = 8'h61;
   localparam logic [ByteW-1:0] CHAR_LD    = 8'h64;
   localparam logic [ByteW-1:0] CHAR_LE    = 8'h65;
   localparam logic [ByteW-1:0] CHAR_LF    = 8'h66;
   localparam logic [ByteW-1:0] CASE_FOLD  = 8'h20;

   // Cipher names, three lower-case letters packed first-letter high
   localparam logic [3*ByteW-1:0] NAME_AES = 24'h616573;  // "aes"
   localparam logic [3*ByteW-1:0] NAME_SGN = 24'h73676E;  // "sgn"
   localparam logic [3*ByteW-1:0] NAME_VRF = 24'h767266;  // "vrf"
   localparam logic [3*ByteW-1:0] NAME_SHA = 24'h736861;  // "sha"

   localparam logic [1:0] CIPH_AES = 2'd0;
   localparam logic [1:0] CIPH_SGN = 2'd1;
   localparam logic [1:0] CIPH_VRF = 2'd2;
   localparam logic [1:0] CIPH_SHA = 2'd3;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_OP      = 3'd1;
   localparam logic [2:0] ST_INDEX_BIG   = 3'd2;
   localparam logic [2:0] ST_BAD_CIPHER  = 3'd3;
   localparam logic [2:0] ST_NO_DELIM    = 3'd4;
   localparam logic [2:0] ST_TOO_LONG    = 3'd5;
   localparam logic [2:0] ST_NON_HEX     = 3'd6;
   localparam logic [2:0] ST_ENDED_EARLY = 3'd7;

   typedef enum logic [2:0] {
      PH_OP,
      PH_INDEX,
      PH_CIPHER,
      PH_DATA,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [ByteW-1:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic              result_kind;
      logic [ByteW-1:0]  data_char;
      logic [2:0]        status;
      logic              op_type;
      logic [IndexW-1:0] key_index;
      logic [1:0]        cipher_type;
      logic              key_kind;
      logic [CountW-1:0] data_length;
   } rsp_payload_type;

   // Stage control from the parse core
   typedef struct packed {
      logic advance;   // input register moves on this cycle
      logic load;      // result register takes a new result
   } ctl_type;

endpackage

[design/ccl_stream_if.sv]
// Valid/ready channel carrying one payload struct per transfer.
// Payload types come from ccl_pkg.
interface ccl_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[design/crypto_command_line_parser.sv]
// Crypto command line parser, top level.
// A req byte passes through the input register, then the result register, to rsp.
// Takes one byte per cycle; no stall but rsp backpressure.
// Synchronous reset clears parse state and loads register defaults.
// Depends on ccl_pkg, ccl_stream_if, ccl_in_stage, ccl_parse_core, ccl_out_stage.
module crypto_command_line_parser
   import ccl_pkg::*;
#(
   parameter int DATA_COUNT_MAX = 4095
) (
   input  logic                clock,
   input  logic                reset,
   ccl_stream_if.sink          req_chan,
   ccl_stream_if.source        rsp_chan,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CountW-1:0]   csr_wdata
);

   ctl_type         ctl;
   logic            in_valid;
   logic [ByteW-1:0] in_byte;
   logic            out_free;
   rsp_payload_type result;

   ccl_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .ctl      (ctl),
      .in_valid (in_valid),
      .in_byte  (in_byte)
   );

   ccl_parse_core #(
      .DATA_COUNT_MAX (DATA_COUNT_MAX)
   ) u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (in_valid),
      .in_byte   (in_byte),
      .out_free  (out_free),
      .ctl       (ctl),
      .result    (result)
   );

   ccl_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

[design/ccl_in_stage.sv]
// Input register of the parser: holds one command byte until the core uses it.
// Depends on ccl_pkg and ccl_stream_if.
module ccl_in_stage
   import ccl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   ccl_stream_if.sink          req_chan,
   input  ctl_type             ctl,
   output logic                in_valid,
   output logic [ByteW-1:0]    in_byte
);

   logic             valid_ff, valid_in;
   logic [ByteW-1:0] byte_ff, byte_in;
   logic             take;

   assign req_chan.ready = !valid_ff || ctl.advance;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_chan.payload.in_byte;
      end else if (ctl.advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

[design/ccl_parse_core.sv]
// Parse state, configuration registers and per-byte decode of the command.
// Depends on ccl_pkg.
module ccl_parse_core
   import ccl_pkg::*;
#(
   parameter int DATA_COUNT_MAX = 4095
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CountW-1:0]   csr_wdata,
   input  logic                in_valid,
   input  logic [ByteW-1:0]    in_byte,
   input  logic                out_free,
   output ctl_type             ctl,
   output rsp_payload_type     result
);

   localparam logic [CountW-1:0] CapMax =
      (DATA_COUNT_MAX > 4095) ? 12'hFFF : CountW'(DATA_COUNT_MAX);

   logic [CountW-1:0]  capacity_ff, capacity_in;
   logic [IndexW-1:0]  max_index_ff, max_index_in;

   phase_type          phase_ff, phase_in;
   logic               delim_ff, delim_in;
   logic               skip_ff, skip_in;
   logic               op_ff, op_in;
   logic [AccumW-1:0]  accum_ff, accum_in;
   logic [2*ByteW-1:0] chars_ff, chars_in;
   logic [1:0]         ccount_ff, ccount_in;
   logic [1:0]         cipher_ff, cipher_in;
   logic [CountW-1:0]  dcount_ff, dcount_in;

   logic [ByteW-1:0]   c;
   logic               is_digit, is_hex;
   logic [12:0]        accum_next;
   logic [CountW-1:0]  limit;
   logic               name_ok;
   logic [1:0]         name_code;
   logic               ev_summary, ev_data;
   logic [2:0]         ev_status;
   logic               advance;

   always_comb begin
      c = in_byte;
      if (in_byte >= CHAR_UA && in_byte <= CHAR_UZ) begin
         c = in_byte + CASE_FOLD;
      end
   end

   assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);
   assign is_hex   = is_digit || ((c >= CHAR_LA) && (c <= CHAR_LF));
   assign accum_next = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                     + {5'd0, c - CHAR_0};
   assign limit = (capacity_ff < CapMax) ? capacity_ff : CapMax;

   always_comb begin
      name_ok   = 1'b1;
      name_code = CIPH_AES;
      unique case ({chars_ff, c})
         NAME_AES: name_code = CIPH_AES;
         NAME_SGN: name_code = CIPH_SGN;
         NAME_VRF: name_code = CIPH_VRF;
         NAME_SHA: name_code = CIPH_SHA;
         default:  name_ok = 1'b0;
      endcase
   end

   // Classify the byte: summary (end or error), data echo, or silent
   always_comb begin
      ev_summary = 1'b0;
      ev_data    = 1'b0;
      ev_status  = ST_OK;
      if (c == CHAR_NUL) begin
         ev_summary = !skip_ff;
         if (delim_ff) begin
            ev_status = ST_NO_DELIM;
         end else begin
            unique case (phase_ff)
               PH_DATA:   ev_status = ST_OK;
               PH_INDEX:  ev_status = (accum_ff > {1'b0, max_index_ff}) ? ST_INDEX_BIG
                                                                      : ST_ENDED_EARLY;
               PH_CIPHER: ev_status = (ccount_ff != 2'd0) ? ST_BAD_CIPHER
                                                          : ST_ENDED_EARLY;
               default:   ev_status = ST_ENDED_EARLY;
            endcase
         end
      end else if (!skip_ff) begin
         if (delim_ff) begin
            if (c != CHAR_COLON) begin
               ev_summary = 1'b1;
               ev_status  = ST_NO_DELIM;
            end
         end else begin
            unique case (phase_ff)
               PH_OP: begin
                  if (c != CHAR_LE && c != CHAR_LD) begin
                     ev_summary = 1'b1;
                     ev_status  = ST_BAD_OP;
                  end
               end
               PH_INDEX: begin
                  if (!is_digit) begin
                     if (accum_ff > {1'b0, max_index_ff}) begin
                        ev_summary = 1'b1;
                        ev_status  = ST_INDEX_BIG;
                     end else if (c != CHAR_COLON) begin
                        ev_summary = 1'b1;
                        ev_status  = ST_NO_DELIM;
                     end
                  end
               end
               PH_CIPHER: begin
                  if (ccount_ff == 2'd2 && !name_ok) begin
                     ev_summary = 1'b1;
                     ev_status  = ST_BAD_CIPHER;
                  end
               end
               PH_DATA: begin
                  ev_summary = 1'b1;
                  if (c == CHAR_NL) begin
                     ev_status = ST_OK;
                  end else if (dcount_ff >= limit) begin
                     ev_status = ST_TOO_LONG;
                  end else if (!is_hex) begin
                     ev_status = ST_NON_HEX;
                  end else begin
                     ev_summary = 1'b0;
                     ev_data    = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign advance     = in_valid && out_free;
   assign ctl.advance = advance;
   assign ctl.load    = advance && (ev_summary || ev_data);

   // Next state
   always_comb begin
      phase_in  = phase_ff;
      delim_in  = delim_ff;
      skip_in   = skip_ff;
      op_in     = op_ff;
      accum_in  = accum_ff;
      chars_in  = chars_ff;
      ccount_in = ccount_ff;
      cipher_in = cipher_ff;
      dcount_in = dcount_ff;
      if (advance) begin
         if (c == CHAR_NUL) begin
            phase_in  = PH_OP;
            delim_in  = 1'b0;
            skip_in   = 1'b0;
            op_in     = OP_ENCRYPT;
            accum_in  = '0;
            chars_in  = '0;
            ccount_in = '0;
            cipher_in = CIPH_AES;
            dcount_in = '0;
         end else if (skip_ff) begin
            skip_in = 1'b1;
         end else if (ev_summary) begin
            skip_in = 1'b1;
         end else if (delim_ff) begin
            delim_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_OP: begin
                  op_in    = (c == CHAR_LD) ? OP_DECRYPT : OP_ENCRYPT;
                  phase_in = PH_INDEX;
                  delim_in = 1'b1;
               end
               PH_INDEX: begin
                  if (is_digit) begin
                     accum_in = (accum_next > {4'd0, ACCUM_SAT}) ? ACCUM_SAT
                                                                : accum_next[8:0];
                  end else begin
                     phase_in = PH_CIPHER;
                  end
               end
               PH_CIPHER: begin
                  if (ccount_ff != 2'd2) begin
                     chars_in  = {chars_ff[ByteW-1:0], c};
                     ccount_in = ccount_ff + 2'd1;
                  end else begin
                     cipher_in = name_code;
                     phase_in  = PH_DATA;
                     delim_in  = 1'b1;
                  end
               end
               PH_DATA: begin
                  dcount_in = dcount_ff + 12'd1;
               end
               default: begin
                  skip_in = 1'b1;
               end
            endcase
         end
      end
   end

   // Result fields
   always_comb begin
      result = '0;
      if (ev_data) begin
         result.result_kind = KIND_DATA;
         result.data_char   = c;
      end else begin
         result.result_kind = KIND_SUMMARY;
         result.status      = ev_status;
         result.op_type     = op_ff;
         result.key_index   = accum_ff[8] ? 8'hFF : accum_ff[7:0];
         result.cipher_type = cipher_ff;
         result.key_kind    = (cipher_ff == CIPH_SGN) || (cipher_ff == CIPH_VRF);
         result.data_length = dcount_ff;
      end
   end

   always_comb begin
      capacity_in  = capacity_ff;
      max_index_in = max_index_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DATA_CAPACITY: capacity_in  = csr_wdata;
            CSR_MAX_KEY_INDEX: max_index_in = csr_wdata[IndexW-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         max_index_ff <= MAX_INDEX_RESET;
         phase_ff     <= PH_OP;
         delim_ff     <= 1'b0;
         skip_ff      <= 1'b0;
         op_ff        <= OP_ENCRYPT;
         accum_ff     <= '0;
         chars_ff     <= '0;
         ccount_ff    <= '0;
         cipher_ff    <= CIPH_AES;
         dcount_ff    <= '0;
      end else begin
         capacity_ff  <= capacity_in;
         max_index_ff <= max_index_in;
         phase_ff     <= phase_in;
         delim_ff     <= delim_in;
         skip_ff      <= skip_in;
         op_ff        <= op_in;
         accum_ff     <= accum_in;
         chars_ff     <= chars_in;
         ccount_ff    <= ccount_in;
         cipher_ff    <= cipher_in;
         dcount_ff    <= dcount_in;
      end
   end

endmodule

[design/ccl_out_stage.sv]
// Result register of the parser, driving the rsp channel.
// Depends on ccl_pkg and ccl_stream_if.
module ccl_out_stage
   import ccl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl,
   input  rsp_payload_type     result,
   output logic                out_free,
   ccl_stream_if.source        rsp_chan
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   // Free when empty or when the held result transfers this cycle
   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = data_ff;

endmodule

[test/crypto_command_line_parser_check.sv]
`timescale 1ns / 100ps
// Checker for crypto_command_line_parser: watches req, rsp and csr transfers,
// keeps its own parse state and compares each result field by field.
// Depends on ccl_pkg.
module crypto_command_line_parser_check
   import ccl_pkg::*;
#(
   parameter int DATA_COUNT_MAX = 4095
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_payload_type   req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_payload_type   rsp_payload,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CountW-1:0] csr_wdata,
   output int                fail_count,
   output int                outstanding,
   output int                checked
);

   localparam int PRINT_CAP = 100;

   logic [CountW-1:0] capacity;
   logic [IndexW-1:0] max_index;

   phase_type         ph;
   logic              delim_due;
   logic              skipping;
   logic              op_r;
   logic [AccumW-1:0] accum;
   logic [15:0]       name_chars;
   logic [1:0]        name_count;
   logic [1:0]        ciph;
   logic [CountW-1:0] dcount;

   // echoes and summaries still due on rsp, oldest first
   rsp_payload_type   parse_out_q[$];

   initial begin
      fail_count = 0;
      outstanding = 0;
      checked = 0;
   end

   task automatic clear_parse();
      ph = PH_OP;
      delim_due = 1'b0;
      skipping = 1'b0;
      op_r = OP_ENCRYPT;
      accum = '0;
      name_chars = '0;
      name_count = '0;
      ciph = CIPH_AES;
      dcount = '0;
   endtask

   function automatic rsp_payload_type summary_of(logic [2:0] st);
      rsp_payload_type s;
      s = '0;
      s.result_kind = KIND_SUMMARY;
      s.status = st;
      s.op_type = op_r;
      s.key_index = (accum > 9'd255) ? 8'd255 : accum[IndexW-1:0];
      s.cipher_type = ciph;
      s.key_kind = (ciph == CIPH_SGN) || (ciph == CIPH_VRF);
      s.data_length = dcount;
      return s;
   endfunction

   // first error or newline close: emit summary now, ignore the rest up to NUL
   task automatic abort_cmd(input logic [2:0] st, output bit hit, output rsp_payload_type res);
      skipping = 1'b1;
      hit = 1'b1;
      res = summary_of(st);
   endtask

   task automatic parse_char(input logic [ByteW-1:0] raw, output bit hit,
                             output rsp_payload_type res);
      logic [ByteW-1:0]   c;
      logic [3*ByteW-1:0] word;
      int                 acc;
      int                 lim;
      c = raw;
      hit = 1'b0;
      res = '0;
      if (c >= CHAR_UA && c <= CHAR_UZ) c = c + CASE_FOLD;
      if (c == CHAR_NUL) begin
         if (!skipping) begin
            hit = 1'b1;
            if (delim_due) res = summary_of(ST_NO_DELIM);
            else if (ph == PH_DATA) res = summary_of(ST_OK);
            else if (ph == PH_INDEX)
               res = summary_of(accum > max_index ? ST_INDEX_BIG : ST_ENDED_EARLY);
            else if (ph == PH_CIPHER)
               res = summary_of(name_count != 0 ? ST_BAD_CIPHER : ST_ENDED_EARLY);
            else res = summary_of(ST_ENDED_EARLY);
         end
         clear_parse();
      end else if (!skipping) begin
         if (delim_due) begin
            if (c == CHAR_COLON) delim_due = 1'b0;
            else abort_cmd(ST_NO_DELIM, hit, res);
         end else begin
            case (ph)
               PH_OP: begin
                  if (c == CHAR_LE || c == CHAR_LD) begin
                     op_r = (c == CHAR_LD) ? OP_DECRYPT : OP_ENCRYPT;
                     ph = PH_INDEX;
                     delim_due = 1'b1;
                  end else abort_cmd(ST_BAD_OP, hit, res);
               end
               PH_INDEX: begin
                  if (c >= CHAR_0 && c <= CHAR_9) begin
                     acc = int'(accum) * 10 + int'(c - CHAR_0);
                     accum = (acc > int'(ACCUM_SAT)) ? ACCUM_SAT : acc[AccumW-1:0];
                  end else if (accum > max_index) abort_cmd(ST_INDEX_BIG, hit, res);
                  else if (c != CHAR_COLON) abort_cmd(ST_NO_DELIM, hit, res);
                  else ph = PH_CIPHER;
               end
               PH_CIPHER: begin
                  if (name_count < 2) begin
                     name_chars = {name_chars[7:0], c};
                     name_count = name_count + 1'b1;
                  end else begin
                     word = {name_chars, c};
                     case (word)
                        NAME_AES: ciph = CIPH_AES;
                        NAME_SGN: ciph = CIPH_SGN;
                        NAME_VRF: ciph = CIPH_VRF;
                        NAME_SHA: ciph = CIPH_SHA;
                        default: abort_cmd(ST_BAD_CIPHER, hit, res);
                     endcase
                     if (!skipping) begin
                        ph = PH_DATA;
                        delim_due = 1'b1;
                     end
                  end
               end
               PH_DATA: begin
                  lim = (int'(capacity) < DATA_COUNT_MAX) ? int'(capacity) : DATA_COUNT_MAX;
                  // newline closes cleanly; length is checked before hex
                  if (c == CHAR_NL) abort_cmd(ST_OK, hit, res);
                  else if (int'(dcount) >= lim) abort_cmd(ST_TOO_LONG, hit, res);
                  else if (!((c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_LA && c <= CHAR_LF)))
                     abort_cmd(ST_NON_HEX, hit, res);
                  else begin
                     dcount = dcount + 1'b1;
                     hit = 1'b1;
                     res.result_kind = KIND_DATA;
                     res.data_char = c;
                  end
               end
               default: skipping = 1'b1;
            endcase
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("%0t rsp transfer %0d, %s: got %0d, expected %0d",
                  $time, checked, what, got, want);
   endtask

   task automatic compare_rsp(input rsp_payload_type got, input rsp_payload_type want);
      if (got.result_kind !== want.result_kind)
         report_mismatch("result_kind", got.result_kind, want.result_kind);
      if (got.data_char !== want.data_char)
         report_mismatch("data_char", got.data_char, want.data_char);
      if (got.status !== want.status)
         report_mismatch("status", got.status, want.status);
      if (got.op_type !== want.op_type)
         report_mismatch("op_type", got.op_type, want.op_type);
      if (got.key_index !== want.key_index)
         report_mismatch("key_index", got.key_index, want.key_index);
      if (got.cipher_type !== want.cipher_type)
         report_mismatch("cipher_type", got.cipher_type, want.cipher_type);
      if (got.key_kind !== want.key_kind)
         report_mismatch("key_kind", got.key_kind, want.key_kind);
      if (got.data_length !== want.data_length)
         report_mismatch("data_length", got.data_length, want.data_length);
   endtask

   always @(posedge clock) begin
      bit              hit;
      rsp_payload_type res;
      if (reset) begin
         capacity = CAPACITY_RESET;
         max_index = MAX_INDEX_RESET;
         clear_parse();
         parse_out_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_DATA_CAPACITY) capacity = csr_wdata;
            else max_index = csr_wdata[IndexW-1:0];
         end
         if (req_valid && req_ready) begin
            parse_char(req_payload.in_byte, hit, res);
            if (hit) parse_out_q.push_back(res);
         end
         if (rsp_valid && rsp_ready) begin
            if (parse_out_q.size() == 0)
               report_mismatch("transfer with nothing due, kind", rsp_payload.result_kind, -1);
            else compare_rsp(rsp_payload, parse_out_q.pop_front());
            checked++;
         end
      end
      outstanding = parse_out_q.size();
   end

endmodule

[test/crypto_command_line_parser_test.sv]
`timescale 1ns / 100ps
// Testbench top for crypto_command_line_parser: clock, reset, command stimulus,
// register settings and the verdict. Depends on ccl_pkg, ccl_stream_if, the
// design and crypto_command_line_parser_check.
module crypto_command_line_parser_test;
   import ccl_pkg::*;

   localparam int DATA_COUNT_MAX = 4095;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 6;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_BYTES    = 220;
   localparam int NUM_PHASES     = 8;

   typedef logic [ByteW-1:0] text_q_type[$];

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic              csr_index;
   logic [CountW-1:0] csr_wdata;

   ccl_stream_if #(.payload_type(req_payload_type)) req_chan ();
   ccl_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   int fail_count;
   int outstanding;
   int checked;
   int cycles = 0;
   int bytes_sent = 0;
   int commands_sent = 0;
   int settings_used = 0;
   int cur_capacity;
   int cur_max;
   bit calm;
   bit hold_req;

   crypto_command_line_parser #(.DATA_COUNT_MAX(DATA_COUNT_MAX)) dut (
      .clock,
      .reset,
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   crypto_command_line_parser_check #(.DATA_COUNT_MAX(DATA_COUNT_MAX)) chk (
      .clock,
      .reset,
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .req_payload(req_chan.payload),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .rsp_payload(rsp_chan.payload),
      .csr_we,
      .csr_index,
      .csr_wdata,
      .fail_count,
      .outstanding,
      .checked
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
         $display("crypto_command_line_parser: mismatch");
         $finish;
      end
   end

   // rsp side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(input logic [ByteW-1:0] b);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload.in_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_command(input text_q_type q);
      foreach (q[i]) send_byte(q[i]);
      commands_sent++;
   endtask

   task automatic send_text(input string s);
      text_q_type q;
      q = {};
      foreach (s[i]) q.push_back(s[i]);
      q.push_back(CHAR_NUL);
      send_command(q);
   endtask

   // wait until every result is in, then let the pipeline empty
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CountW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [ByteW-1:0] rand_case(input logic [ByteW-1:0] c);
      if (c >= CHAR_LA && c <= "z" && $urandom_range(0, 1) == 1) return c - CASE_FOLD;
      return c;
   endfunction

   function automatic logic [ByteW-1:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return ByteW'(CHAR_0 + v);
      return rand_case(ByteW'(CHAR_LA + v - 10));
   endfunction

   function automatic logic [ByteW-1:0] noise_byte();
      return ByteW'($urandom_range(1, 255));
   endfunction

   task automatic build_command(output text_q_type q, input int data_max);
      string              idx_text;
      logic [3*ByteW-1:0] name;
      int                 mode;
      int                 n;
      int                 pos;
      q = {};
      mode = $urandom_range(0, 99);
      if (mode >= 92) begin
         repeat ($urandom_range(1, 12)) q.push_back(noise_byte());
         q.push_back(CHAR_NUL);
         return;
      end
      q.push_back(rand_case($urandom_range(0, 1) == 1 ? CHAR_LE : CHAR_LD));
      q.push_back(CHAR_COLON);
      // key index: right at the limit, one past it, or free digits
      if ($urandom_range(0, 2) == 0) begin
         idx_text = $sformatf("%0d", $urandom_range(0, 1) == 1 ? cur_max : cur_max + 1);
         if ($urandom_range(0, 3) == 0) idx_text = {"0", idx_text};
         foreach (idx_text[i]) q.push_back(idx_text[i]);
      end else begin
         repeat ($urandom_range(0, 4)) q.push_back(ByteW'(CHAR_0 + $urandom_range(0, 9)));
      end
      q.push_back(CHAR_COLON);
      case ($urandom_range(0, 3))
         0: name = NAME_AES;
         1: name = NAME_SGN;
         2: name = NAME_VRF;
         default: name = NAME_SHA;
      endcase
      if ($urandom_range(0, 9) == 0) begin
         pos = $urandom_range(0, 2);
         name[8*pos +: 8] = ByteW'(CHAR_LA + $urandom_range(0, 25));
      end
      for (int i = 2; i >= 0; i--) q.push_back(rand_case(name[8*i +: 8]));
      q.push_back(CHAR_COLON);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, data_max) : $urandom_range(0, 12);
      repeat (n) q.push_back(hex_char());
      if ($urandom_range(0, 3) == 0) begin
         q.push_back(CHAR_NL);
         repeat ($urandom_range(0, 3)) q.push_back(noise_byte());
      end
      q.push_back(CHAR_NUL);
      if (mode >= 70 && mode < 85) begin
         // one wrong byte somewhere before the end
         pos = $urandom_range(0, q.size() - 2);
         case ($urandom_range(0, 5))
            0: q[pos] = CHAR_COLON;
            1: q[pos] = CHAR_NL;
            2: q[pos] = "g";
            3: q[pos] = ByteW'(CHAR_0 + $urandom_range(0, 9));
            default: q[pos] = noise_byte();
         endcase
      end else if (mode >= 85) begin
         // cut short, sometimes down to nothing
         pos = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, q.size() - 1);
         while (q.size() > pos) void'(q.pop_back());
         q.push_back(CHAR_NUL);
      end
   endtask

   initial begin
      text_q_type q;
      int         phase_start;
      int         data_max;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_DATA_CAPACITY;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      calm = 1'b0;
      hold_req = 1'b0;
      cur_capacity = CAPACITY_RESET;
      cur_max = MAX_INDEX_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: folding, empty index, bad op, end in index too big, newline close
      send_text("D::SGN:F0");
      send_text("q");
      send_text("e:300");
      send_text("e:7:sha:1\nzz");
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin cur_capacity = 0; cur_max = 0; end
            1: begin cur_capacity = 4095; cur_max = 255; end
            2: begin cur_capacity = 5; cur_max = 9; end
            3: begin cur_capacity = 1; cur_max = 100; end
            4: begin cur_capacity = $urandom_range(0, 4095); cur_max = $urandom_range(0, 255); end
            5: begin cur_capacity = 3; cur_max = 255; end
            6: begin cur_capacity = $urandom_range(0, 20); cur_max = $urandom_range(0, 255); end
            default: begin cur_capacity = 4095; cur_max = 255; end
         endcase
         write_reg(CSR_DATA_CAPACITY, CountW'(cur_capacity));
         write_reg(CSR_MAX_KEY_INDEX, CountW'(cur_max));
         settings_used++;
         data_max = (cur_capacity < 64) ? cur_capacity + 2 : 40;
         // long rsp hold-off while commands keep coming
         if (p == 1) hold_req = 1'b1;
         if (p == NUM_PHASES - 1) calm = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_command(q, data_max);
            send_command(q);
         end
         settle();
      end

      $display("Ran %0d commands (%0d bytes) under %0d register settings; %0d results checked.",
               commands_sent, bytes_sent, settings_used, checked);
      if (fail_count == 0) begin
         $display("crypto_command_line_parser: match");
      end else begin
         $display("crypto_command_line_parser: mismatch");
      end
      $finish;
   end

endmodule
